FILE: rtl/lmsf_pkg.sv
// Package for the lean mixture shutdown machine: word types, stage codes,
// configuration register indexes and size constants.
// No dependencies.
package lmsf_pkg;

  localparam int unsigned SENSORS         = 4;
  localparam int unsigned SENSOR_SLOTS    = 4;
  localparam int unsigned TIMER_BITS_DFLT = 16;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam logic [15:0] FIXED_LOAD      = 16'hFFFF;

  typedef enum logic [1:0] {
    STAGE_NORMAL    = 2'd0,
    STAGE_SPARK_CUT = 2'd1,
    STAGE_FUEL_CUT  = 2'd2
  } stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPTIONS        = 3'd0,
    REG_ENABLE_RPM     = 3'd1,
    REG_ENABLE_LOAD    = 3'd2,
    REG_WARN_TIME      = 3'd3,
    REG_SPARK_CUT_TIME = 3'd4,
    REG_RETURN_TPS     = 3'd5,
    REG_RETURN_MAP     = 3'd6,
    REG_RETURN_RPM     = 3'd7
  } cfg_reg_t;

  // Load select codes held in options bits 2:1.
  localparam logic [1:0] LOAD_SEL_MAP      = 2'd0;
  localparam logic [1:0] LOAD_SEL_THROTTLE = 2'd1;

  localparam logic FUNC_EVALUATE = 1'b0;
  localparam logic FUNC_TICK     = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] engine_rpm;
    logic [15:0] map_kpa;
    logic [9:0]  throttle;
    logic        egt_request;
    logic        cut_active;
    logic [7:0]  afr_target;
    logic [7:0]  lean_margin;
    logic [7:0]  afr_0;
    logic [7:0]  afr_1;
    logic [7:0]  afr_2;
    logic [7:0]  afr_3;
  } in_word_t;

  typedef struct packed {
    logic       warn_pin;
    logic [1:0] stage;
    logic       lean_warning;
    logic       lean_shutdown;
  } out_word_t;

endpackage

FILE: rtl/lean_mixture_shutdown_fsm.sv
// Lean mixture shutdown machine, top level: configuration registers, stage
// state machine and the registered result word. Depends on lmsf_pkg.
//
// Every input word produces exactly one result word, which shows the state
// after that word has been applied. The state update is one level of
// compares and selects between the state registers and the output register,
// so one word is taken every clock cycle; in_ready is low only while a
// result waits in the output register and out_ready is low. A word's result
// appears on the cycle after it is accepted. The timer counts tick words
// only while it is nonzero and saturates at all ones of TIMER_BITS.
// Configuration writes are always accepted and should be made while idle.
module lean_mixture_shutdown_fsm #(
  parameter int unsigned TIMER_BITS = lmsf_pkg::TIMER_BITS_DFLT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lmsf_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lmsf_pkg::out_word_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lmsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lmsf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  // Configuration registers.
  logic [2:0]  options_r;
  logic [15:0] enable_rpm_r, enable_load_r, warn_time_r, spark_cut_time_r;
  logic [9:0]  return_tps_r;
  logic [15:0] return_map_r, return_rpm_r;

  // Machine state.
  lmsf_pkg::stage_t        stage_r, stage_nxt;
  logic [TIMER_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic                    warn_r, warn_nxt;
  logic                    shut_r, shut_nxt;
  logic                    pin_r, pin_nxt;

  logic                    out_valid_r;
  lmsf_pkg::out_word_t     out_data_r;

  logic                    in_fire;
  logic [15:0]             load;
  logic                    below_enable;
  logic                    lean;
  logic                    hold_req;
  logic [8:0]              lean_limit;
  logic [7:0]              afr [lmsf_pkg::SENSOR_SLOTS];
  logic [CmpW-1:0]         elapsed_ext;
  logic                    past_warn;
  logic                    past_spark;
  logic                    may_return;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      options_r        <= '0;
      enable_rpm_r     <= '0;
      enable_load_r    <= '0;
      warn_time_r      <= '0;
      spark_cut_time_r <= '0;
      return_tps_r     <= '0;
      return_map_r     <= '0;
      return_rpm_r     <= '0;
    end else if (cfg_valid) begin
      case (lmsf_pkg::cfg_reg_t'(cfg_index))
        lmsf_pkg::REG_OPTIONS:        options_r        <= cfg_data[2:0];
        lmsf_pkg::REG_ENABLE_RPM:     enable_rpm_r     <= cfg_data;
        lmsf_pkg::REG_ENABLE_LOAD:    enable_load_r    <= cfg_data;
        lmsf_pkg::REG_WARN_TIME:      warn_time_r      <= cfg_data;
        lmsf_pkg::REG_SPARK_CUT_TIME: spark_cut_time_r <= cfg_data;
        lmsf_pkg::REG_RETURN_TPS:     return_tps_r     <= cfg_data[9:0];
        lmsf_pkg::REG_RETURN_MAP:     return_map_r     <= cfg_data;
        lmsf_pkg::REG_RETURN_RPM:     return_rpm_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign afr[0] = in_data.afr_0;
  assign afr[1] = in_data.afr_1;
  assign afr[2] = in_data.afr_2;
  assign afr[3] = in_data.afr_3;

  // A reading is lean when it exceeds target plus margin; nine bits hold the sum.
  assign lean_limit = {1'b0, in_data.afr_target} + {1'b0, in_data.lean_margin};

  always_comb begin
    lean = 1'b0;
    for (int i = 0; i < lmsf_pkg::SENSORS; i++) begin
      if ({1'b0, afr[i]} > lean_limit) begin
        lean = 1'b1;
      end
    end
  end

  always_comb begin
    case (options_r[2:1])
      lmsf_pkg::LOAD_SEL_MAP:      load = in_data.map_kpa;
      lmsf_pkg::LOAD_SEL_THROTTLE: load = {6'd0, in_data.throttle};
      default:                     load = lmsf_pkg::FIXED_LOAD;
    endcase
  end

  assign below_enable = (in_data.engine_rpm < enable_rpm_r) || (load < enable_load_r)
                        || in_data.cut_active;
  assign hold_req     = in_data.egt_request || lean;
  assign elapsed_ext  = CmpW'(elapsed_r);
  assign past_warn    = elapsed_ext > CmpW'(warn_time_r);
  assign past_spark   = elapsed_ext > CmpW'(spark_cut_time_r);
  assign may_return   = (in_data.throttle < return_tps_r) && (in_data.map_kpa < return_map_r)
                        && (in_data.engine_rpm < return_rpm_r) && !in_data.egt_request;

  always_comb begin
    stage_nxt   = stage_r;
    elapsed_nxt = elapsed_r;
    warn_nxt    = warn_r;
    shut_nxt    = shut_r;
    pin_nxt     = pin_r;
    if (in_data.func == lmsf_pkg::FUNC_TICK) begin
      if ((elapsed_r != '0) && (elapsed_r != '1)) begin
        elapsed_nxt = elapsed_r + TIMER_BITS'(1);
      end
    end else begin
      case (stage_r)
        lmsf_pkg::STAGE_NORMAL: begin
          if (!options_r[0]) begin
            pin_nxt = in_data.egt_request;
          end else if (below_enable) begin
            elapsed_nxt = '0;
            if (!in_data.egt_request) begin
              pin_nxt = 1'b0;
            end
          end else begin
            warn_nxt = lean;
            if (!lean) begin
              shut_nxt = 1'b0;
            end
            if (!hold_req) begin
              elapsed_nxt = '0;
              pin_nxt     = 1'b0;
            end else if (elapsed_r == '0) begin
              pin_nxt     = 1'b1;
              elapsed_nxt = TIMER_BITS'(1);
            end else if (past_warn) begin
              stage_nxt   = lmsf_pkg::STAGE_SPARK_CUT;
              elapsed_nxt = TIMER_BITS'(1);
              if (lean) begin
                shut_nxt = 1'b1;
              end
            end
          end
        end
        lmsf_pkg::STAGE_SPARK_CUT: begin
          if (past_spark) begin
            elapsed_nxt = '0;
            stage_nxt   = lmsf_pkg::STAGE_FUEL_CUT;
          end
        end
        lmsf_pkg::STAGE_FUEL_CUT: begin
          if (may_return) begin
            stage_nxt = lmsf_pkg::STAGE_NORMAL;
            warn_nxt  = 1'b0;
            shut_nxt  = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= lmsf_pkg::STAGE_NORMAL;
      elapsed_r   <= '0;
      warn_r      <= 1'b0;
      shut_r      <= 1'b0;
      pin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        stage_r     <= stage_nxt;
        elapsed_r   <= elapsed_nxt;
        warn_r      <= warn_nxt;
        shut_r      <= shut_nxt;
        pin_r       <= pin_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.warn_pin      <= pin_nxt;
      out_data_r.stage         <= stage_nxt;
      out_data_r.lean_warning  <= warn_nxt;
      out_data_r.lean_shutdown <= shut_nxt;
    end
  end

endmodule

FILE: rtl/lmsf_checker.sv
// Port-level checker for the lean mixture shutdown machine, with the bind
// that attaches it to the top level. Depends on lmsf_pkg.
module lmsf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input lmsf_pkg::out_word_t             out_data
);

  // A result word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped while stalled");

  // Every accepted input word yields a result on the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A lean shutdown is only flagged once the machine has left normal.
  a_shut_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.lean_shutdown |->
      (out_data.stage == lmsf_pkg::STAGE_SPARK_CUT) ||
      (out_data.stage == lmsf_pkg::STAGE_FUEL_CUT))
    else $error("lean shutdown flagged in normal stage");

  // Stage code three is never reported.
  a_stage_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.stage != 2'd3)
    else $error("invalid stage code on result");

endmodule

bind lean_mixture_shutdown_fsm lmsf_checker u_lmsf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: bench/lean_mixture_shutdown_fsm_test.sv
`timescale 1ns / 100ps
// Testbench for lean_mixture_shutdown_fsm: drives evaluate and tick words, keeps its
// own copy of the stage machine and checks every result word against it.
// Depends on lmsf_pkg and the lean_mixture_shutdown_fsm RTL.
module lean_mixture_shutdown_fsm_test;
  import lmsf_pkg::*;

  localparam int PERIOD       = 12;
  localparam int LIMIT_CYCLES = 100_000;
  localparam int LONG_TICKS   = 40;

  // Tracks the stage machine and holds the status words still owed by the block.
  class shutdown_scoreboard;
    logic [2:0]                 opt;
    logic [15:0]                en_rpm, en_load, warn_limit, cut_limit, ret_map, ret_rpm;
    logic [9:0]                 ret_tps;
    stage_t                     stage;
    logic [TIMER_BITS_DFLT-1:0] timer;
    logic                       warn_f, shut_f, pin;
    out_word_t                  status_q[$];
    int                         errors;

    function new();
      opt = '0;
      en_rpm = '0;
      en_load = '0;
      warn_limit = '0;
      cut_limit = '0;
      ret_tps = '0;
      ret_map = '0;
      ret_rpm = '0;
      stage = STAGE_NORMAL;
      timer = '0;
      warn_f = 1'b0;
      shut_f = 1'b0;
      pin = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [15:0] v);
      case (r)
        REG_OPTIONS:        opt = v[2:0];
        REG_ENABLE_RPM:     en_rpm = v;
        REG_ENABLE_LOAD:    en_load = v;
        REG_WARN_TIME:      warn_limit = v;
        REG_SPARK_CUT_TIME: cut_limit = v;
        REG_RETURN_TPS:     ret_tps = v[9:0];
        REG_RETURN_MAP:     ret_map = v;
        REG_RETURN_RPM:     ret_rpm = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    // Normal stage evaluation: enable gating, lean comparison and warn timing.
    function void judge_mixture(in_word_t w);
      logic [7:0]  reading [SENSOR_SLOTS];
      logic [15:0] load;
      logic        flag, lean;
      int          diff;
      reading[0] = w.afr_0;
      reading[1] = w.afr_1;
      reading[2] = w.afr_2;
      reading[3] = w.afr_3;
      flag = w.egt_request;
      lean = 1'b0;
      if (!opt[0]) begin
        pin = w.egt_request;
        return;
      end
      case (opt[2:1])
        LOAD_SEL_MAP:      load = w.map_kpa;
        LOAD_SEL_THROTTLE: load = {6'd0, w.throttle};
        default:           load = FIXED_LOAD;
      endcase
      if (w.engine_rpm < en_rpm || load < en_load || w.cut_active) begin
        timer = '0;
        if (!flag) pin = 1'b0;
        return;
      end
      for (int i = 0; i < SENSORS; i++) begin
        diff = int'(reading[i]) - int'(w.afr_target);
        if (diff > int'(w.lean_margin)) lean = 1'b1;
      end
      if (lean) begin
        warn_f = 1'b1;
        flag = 1'b1;
      end else begin
        warn_f = 1'b0;
        shut_f = 1'b0;
      end
      if (flag) begin
        if (timer == '0) begin
          pin = 1'b1;
          timer = TIMER_BITS_DFLT'(1);
        end else if (timer > warn_limit) begin
          stage = STAGE_SPARK_CUT;
          timer = TIMER_BITS_DFLT'(1);
          if (warn_f) shut_f = 1'b1;
        end
      end else begin
        timer = '0;
        pin = 1'b0;
      end
    endfunction

    function void take_word(in_word_t w);
      out_word_t s;
      if (w.func == FUNC_TICK) begin
        if (timer != '0 && timer != '1) timer = timer + 1'b1;
      end else begin
        case (stage)
          STAGE_NORMAL: judge_mixture(w);
          STAGE_SPARK_CUT: begin
            if (timer > cut_limit) begin
              timer = '0;
              stage = STAGE_FUEL_CUT;
            end
          end
          STAGE_FUEL_CUT: begin
            if (w.throttle < ret_tps && w.map_kpa < ret_map && w.engine_rpm < ret_rpm &&
                !w.egt_request) begin
              stage = STAGE_NORMAL;
              warn_f = 1'b0;
              shut_f = 1'b0;
            end
          end
          default: ;
        endcase
      end
      s.warn_pin = pin;
      s.stage = stage;
      s.lean_warning = warn_f;
      s.lean_shutdown = shut_f;
      status_q.push_back(s);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_status(out_word_t got);
      out_word_t want;
      if (status_q.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing outstanding", got));
        return;
      end
      want = status_q.pop_front();
      if (got.warn_pin !== want.warn_pin)
        report_mismatch($sformatf("warn_pin %b, expected %b", got.warn_pin, want.warn_pin));
      if (got.stage !== want.stage)
        report_mismatch($sformatf("stage %0d, expected %0d", got.stage, want.stage));
      if (got.lean_warning !== want.lean_warning)
        report_mismatch($sformatf("lean_warning %b, expected %b",
                                  got.lean_warning, want.lean_warning));
      if (got.lean_shutdown !== want.lean_shutdown)
        report_mismatch($sformatf("lean_shutdown %b, expected %b",
                                  got.lean_shutdown, want.lean_shutdown));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  shutdown_scoreboard sb = new();
  bit                 sender_calm = 1'b0;
  bit                 hold_results = 1'b0;

  lean_mixture_shutdown_fsm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  initial begin : watchdog
    #(LIMIT_CYCLES * PERIOD);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int next_gap();
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    return sender_calm ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic send_word(in_word_t w, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.take_word(w);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(r, v);
  endtask

  // Waits for the block to drain, then rewrites every register.
  task automatic apply_settings(logic [2:0] opts, logic [15:0] erpm, logic [15:0] eload,
                                logic [15:0] warn, logic [15:0] spark, logic [9:0] rtps,
                                logic [15:0] rmap, logic [15:0] rrpm);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(REG_OPTIONS, {13'd0, opts});
    write_reg(REG_ENABLE_RPM, erpm);
    write_reg(REG_ENABLE_LOAD, eload);
    write_reg(REG_WARN_TIME, warn);
    write_reg(REG_SPARK_CUT_TIME, spark);
    write_reg(REG_RETURN_TPS, {6'd0, rtps});
    write_reg(REG_RETURN_MAP, rmap);
    write_reg(REG_RETURN_RPM, rrpm);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t eval_word(logic [15:0] rpm, logic [15:0] map, logic [9:0] tps,
                                         logic egt, logic cut, logic [7:0] target,
                                         logic [7:0] margin, logic [7:0] a0, logic [7:0] a1,
                                         logic [7:0] a2, logic [7:0] a3);
    in_word_t w;
    w.func = FUNC_EVALUATE;
    w.engine_rpm = rpm;
    w.map_kpa = map;
    w.throttle = tps;
    w.egt_request = egt;
    w.cut_active = cut;
    w.afr_target = target;
    w.lean_margin = margin;
    w.afr_0 = a0;
    w.afr_1 = a1;
    w.afr_2 = a2;
    w.afr_3 = a3;
    return w;
  endfunction

  // A tick carries random content in its other fields, which the block must ignore.
  function automatic in_word_t tick_word();
    in_word_t w;
    w = eval_word(16'($urandom), 16'($urandom), 10'($urandom_range(0, 1000)),
                  1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    w.func = FUNC_TICK;
    return w;
  endfunction

  // Mostly words that pass the enable points in normal stage and fall under the
  // return points in fuel cut; one in ten is left fully random.
  function automatic in_word_t random_item();
    in_word_t   w;
    logic [7:0] reading [SENSOR_SLOTS];
    int         ceiling;
    w = tick_word();
    w.func = ($urandom_range(0, 99) < 35) ? FUNC_TICK : FUNC_EVALUATE;
    if ($urandom_range(0, 9) == 0) return w;
    w.egt_request = ($urandom_range(0, 4) == 0);
    w.cut_active = ($urandom_range(0, 15) == 0);
    if (sb.stage == STAGE_FUEL_CUT) begin
      if (sb.ret_rpm != 0 && $urandom_range(0, 3) != 0)
        w.engine_rpm = 16'($urandom_range(0, int'(sb.ret_rpm) - 1));
      if (sb.ret_map != 0 && $urandom_range(0, 3) != 0)
        w.map_kpa = 16'($urandom_range(0, int'(sb.ret_map) - 1));
      if (sb.ret_tps != 0 && $urandom_range(0, 3) != 0)
        w.throttle = 10'($urandom_range(0, int'(sb.ret_tps) - 1));
    end else begin
      if ($urandom_range(0, 4) != 0)
        w.engine_rpm = 16'($urandom_range(int'(sb.en_rpm), 65535));
      if ($urandom_range(0, 4) != 0) w.map_kpa = 16'($urandom_range(int'(sb.en_load), 65535));
      if (sb.en_load <= 1000 && $urandom_range(0, 4) != 0)
        w.throttle = 10'($urandom_range(int'(sb.en_load), 1000));
      w.afr_target = 8'($urandom_range(0, 200));
      w.lean_margin = 8'($urandom_range(0, 40));
      ceiling = int'(w.afr_target) + int'(w.lean_margin);
      for (int i = 0; i < SENSOR_SLOTS; i++) begin
        case ($urandom_range(0, 5))
          0:       reading[i] = 8'($urandom_range(ceiling + 1, 255));
          1:       reading[i] = 8'(ceiling);
          default: reading[i] = 8'($urandom_range(0, ceiling));
        endcase
      end
      w.afr_0 = reading[0];
      w.afr_1 = reading[1];
      w.afr_2 = reading[2];
      w.afr_3 = reading[3];
    end
    return w;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_word(random_item(), next_gap());
  endtask

  initial begin : result_sink
    int stall;
    bit calm;
    calm = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        // Long stall so the single result slot fills and the input backs up.
        hold_results = 1'b0;
        out_ready <= 1'b0;
        repeat (60) @(negedge clk);
      end
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_status(out_data);
      if ($urandom_range(0, 49) == 0) calm = !calm;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Lean check off after reset: the pin follows the temperature request.
    send_word(eval_word(0, 0, 0, 1, 0, 0, 0, 255, 255, 255, 255), next_gap());
    send_word(tick_word(), next_gap());
    send_word(eval_word(0, 0, 0, 0, 0, 0, 0, 255, 255, 255, 255), next_gap());

    apply_settings(3'd1, 1000, 200, 2, 1, 100, 300, 900);
    send_word(eval_word(999, 65535, 1000, 0, 0, 0, 0, 255, 0, 0, 0), next_gap());
    // A reading exactly at target plus margin is not lean; one above it is.
    send_word(eval_word(1000, 200, 0, 0, 0, 100, 20, 120, 0, 50, 100), next_gap());
    send_word(eval_word(1000, 200, 0, 0, 0, 100, 20, 121, 0, 50, 100), next_gap());
    repeat (3) send_word(tick_word(), next_gap());
    send_word(eval_word(65535, 65535, 1000, 0, 0, 0, 254, 0, 0, 0, 255), next_gap());
    send_word(eval_word(65535, 65535, 1000, 0, 0, 0, 254, 0, 0, 0, 255), next_gap());
    send_word(tick_word(), next_gap());
    send_word(eval_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), next_gap());
    send_word(tick_word(), next_gap());
    send_word(eval_word(0, 0, 1000, 0, 0, 0, 0, 0, 0, 0, 0), next_gap());
    send_word(eval_word(899, 299, 99, 1, 0, 0, 0, 0, 0, 0, 0), next_gap());
    send_word(eval_word(899, 299, 99, 0, 0, 0, 0, 0, 0, 0, 0), next_gap());
    send_word(eval_word(65535, 65535, 500, 1, 1, 0, 0, 255, 255, 255, 255), next_gap());
    send_word(eval_word(65535, 65535, 500, 0, 1, 0, 0, 255, 255, 255, 255), next_gap());
    send_word(eval_word(5000, 5000, 500, 1, 0, 255, 255, 255, 255, 255, 255), next_gap());
    send_word(eval_word(5000, 5000, 500, 0, 0, 128, 0, 127, 0, 1, 128), next_gap());

    // A back-to-back tick run against a distant warn time: the timer keeps
    // counting and the machine stays in normal stage.
    apply_settings(3'd1, 0, 0, 65534, 0, 1000, 65535, 65535);
    send_word(eval_word(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0), next_gap());
    repeat (LONG_TICKS) send_word(tick_word(), 0);
    send_word(eval_word(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0), next_gap());
    send_word(eval_word(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0), next_gap());
    send_word(eval_word(0, 0, 999, 0, 0, 0, 0, 0, 0, 0, 0), next_gap());

    apply_settings(3'd3, 3000, 300, 3, 2, 500, 40000, 4000);
    run_random(110);
    apply_settings(3'd5, 0, 65535, 0, 0, 1000, 65535, 65535);
    hold_results = 1'b1;
    run_random(110);
    apply_settings(3'd7, 65535, 0, 65535, 65535, 0, 0, 0);
    run_random(60);
    apply_settings(3'd1, 16'($urandom_range(0, 8000)), 16'($urandom_range(0, 30000)),
                   16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                   10'($urandom_range(0, 1000)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
    run_random(120);
    apply_settings(3'd6, 200, 100, 1, 1, 300, 20000, 3000);
    run_random(50);
    apply_settings(3'd4, 1000, 1000, 2, 2, 800, 50000, 6000);
    run_random(40);
    apply_settings(3'd1, 16'($urandom_range(0, 4000)), 16'($urandom_range(0, 20000)),
                   16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                   10'($urandom_range(0, 1000)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
    run_random(130);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
